// ----- design/crsb_pkg.sv -----
// ----------------------------------------------------------------------------
// crsb_pkg: shared types and constants of the chunked ring stream buffer
// Field widths, action and result codes, register indexes, sequencer states,
// word types.
// ----------------------------------------------------------------------------
package crsb_pkg;

	localparam int LEN_W     = 21;
	localparam int OFS_W     = 20;
	localparam int ADDR_W    = 19;
	localparam int SUM_W     = 22;
	localparam int IL_W      = 16;
	localparam int MASK_W    = 24;
	localparam int CH_W      = 5;
	localparam int NCH_W     = 5;
	localparam int KIND_W    = 2;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam int MIN_RING_BYTES = 16;

	localparam logic ACT_FEED  = 1'b0;
	localparam logic ACT_CHUNK = 1'b1;

	localparam logic [KIND_W-1:0] KIND_FEED     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOP     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNDERRUN = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_BUFFER_BYTES     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INTERLEAVE_BYTES = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_ENABLE   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REFILL_LEVEL     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_BASE      = 3'd4;

	localparam logic [LEN_W-1:0]  RST_BUFFER_BYTES     = 21'd65536;
	localparam logic [IL_W-1:0]   RST_INTERLEAVE_BYTES = 16'd2048;
	localparam logic [MASK_W-1:0] RST_CHANNEL_ENABLE   = 24'd3;
	localparam logic [LEN_W-1:0]  RST_REFILL_LEVEL     = 21'd16384;
	localparam logic [ADDR_W-1:0] RST_TARGET_BASE      = 19'd4112;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FEED_WRAP,
		ST_FEED_OUT,
		ST_COUNT,
		ST_MUL,
		ST_CHECK,
		ST_UNDER,
		ST_DRAIN_WRAP,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic             action;
		logic [LEN_W-1:0] feed_length;
	} in_word_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CH_W-1:0]   channel;
		logic [ADDR_W-1:0] loop_address;
		logic [ADDR_W-1:0] upload_address;
		logic [OFS_W-1:0]  read_offset;
		logic [OFS_W-1:0]  write_offset;
		logic [LEN_W-1:0]  accepted_length;
		logic [LEN_W-1:0]  free_contiguous;
		logic [LEN_W-1:0]  free_total;
		logic [LEN_W-1:0]  fill_bytes;
		logic              refill_request;
		logic              last;
	} out_word_t;

endpackage

// ----- design/crsb_wrap.sv -----
// ----------------------------------------------------------------------------
// crsb_wrap: iterative ring offset wrap
// Restoring remainder of offset + length by the ring size, one bit a cycle.
// ----------------------------------------------------------------------------
module crsb_wrap (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [crsb_pkg::SUM_W-1:0]  dividend,
	input  logic [crsb_pkg::LEN_W-1:0]  divisor,
	output logic                        done,
	output logic [crsb_pkg::LEN_W-1:0]  remainder
);
	import crsb_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] dvd_q;
	logic [LEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   diff;

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits the divisor width
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[LEN_W-1:0];
			end else begin
				rem_q <= trial[LEN_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- design/chunked_ring_stream_buffer.sv -----
// ----------------------------------------------------------------------------
// chunked_ring_stream_buffer: byte ring bookkeeping for a chunked audio stream
// Feed words advance the write offset, chunk requests drain one chunk and
// emit one loop entry per enabled channel, or one underrun result instead.
// ----------------------------------------------------------------------------
// A feed word is accepted, then the bit-serial wrap unit reduces the new write
// offset modulo the ring size and hands over the remainder, then the report
// goes out. A chunk request counts enabled channels (one mask bit a cycle), does
// the chunk multiply and the underrun check, runs the same wrap unit for the
// read offset, then scans one channel slot per cycle up to the last enabled
// channel (at most 24 slots; a stalled entry holds the scan), one entry per
// enabled channel. A stalled result register holds the sequencer in the report
// or entry cycle until the slot frees up.
// An underrun answers after the check with one result and leaves state as is.
// The block takes one word at a time; a finished result waits in the output
// register while the next word is accepted. Configuration must be written
// through the APB port only while the block is idle; the block does not enforce it.
module chunked_ring_stream_buffer #(
	parameter int MAX_RING_BYTES = 1048576,
	parameter int NUM_VOICES     = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crsb_pkg::PADDR_W-1:0]  paddr,
	input  logic [crsb_pkg::PDATA_W-1:0]  pwdata,
	output logic [crsb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  crsb_pkg::in_word_t            req_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output crsb_pkg::out_word_t           res_data
);
	import crsb_pkg::*;

	localparam int LEN_MAX  = (1 << LEN_W) - 1;
	localparam int SIZE_MAX = (MAX_RING_BYTES < LEN_MAX) ? MAX_RING_BYTES : LEN_MAX;
	localparam int POS_W    = $clog2(SIZE_MAX);
	localparam logic [MASK_W-1:0] VOICE_MASK = (NUM_VOICES >= MASK_W) ?
		{MASK_W{1'b1}} : MASK_W'((64'd1 << NUM_VOICES) - 64'd1);

	// configuration
	logic [LEN_W-1:0]  buffer_bytes_q;
	logic [IL_W-1:0]   interleave_q;
	logic [MASK_W-1:0] channel_enable_q;
	logic [LEN_W-1:0]  refill_level_q;
	logic [ADDR_W-1:0] target_base_q;
	logic              cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	// ring state
	logic [POS_W-1:0] wr_pos_q;
	logic [POS_W-1:0] rd_pos_q;
	logic [LEN_W-1:0] fill_q;
	logic             half_q;
	logic             refill_sent_q;

	// sequencer
	seq_state_t        state_q, state_d;
	logic [CH_W-1:0]   idx_q;
	logic [NCH_W-1:0]  nch_q;
	logic [MASK_W-1:0] mask_q;
	logic [LEN_W-1:0]  acc_q;
	logic [LEN_W-1:0]  chunk_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] offset_q;
	logic [POS_W-1:0]  start_q;
	logic              req_q;

	logic              res_valid_q;
	out_word_t         res_data_q;

	// combinational
	logic [LEN_W-1:0]  size_w;
	logic [LEN_W-1:0]  ft_w;
	logic [LEN_W-1:0]  fc_raw;
	logic [LEN_W-1:0]  fc_w;
	logic [LEN_W-1:0]  acc_w;
	logic [LEN_W-1:0]  fill_feed_w;
	logic [LEN_W-1:0]  fill_drain_w;
	logic              underrun_w;
	logic              slot_free;
	logic              ch_hit;
	logic              accept;
	logic              wrap_start;
	logic              load_out;
	logic [SUM_W-1:0]  wrap_dvd;
	logic              wrap_done;
	logic [LEN_W-1:0]  wrap_rem;
	out_word_t         out_w;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[REG_IDX_W+1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_bytes_q   <= RST_BUFFER_BYTES;
			interleave_q     <= RST_INTERLEAVE_BYTES;
			channel_enable_q <= RST_CHANNEL_ENABLE;
			refill_level_q   <= RST_REFILL_LEVEL;
			target_base_q    <= RST_TARGET_BASE;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BUFFER_BYTES:     buffer_bytes_q   <= pwdata[LEN_W-1:0];
				REG_INTERLEAVE_BYTES: interleave_q     <= pwdata[IL_W-1:0];
				REG_CHANNEL_ENABLE:   channel_enable_q <= pwdata[MASK_W-1:0];
				REG_REFILL_LEVEL:     refill_level_q   <= pwdata[LEN_W-1:0];
				REG_TARGET_BASE:      target_base_q    <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BUFFER_BYTES:     prdata = PDATA_W'(buffer_bytes_q);
			REG_INTERLEAVE_BYTES: prdata = PDATA_W'(interleave_q);
			REG_CHANNEL_ENABLE:   prdata = PDATA_W'(channel_enable_q);
			REG_REFILL_LEVEL:     prdata = PDATA_W'(refill_level_q);
			REG_TARGET_BASE:      prdata = PDATA_W'(target_base_q);
			default:              prdata = '0;
		endcase
	end

	// ---------------- ring arithmetic ----------------
	always_comb begin
		if (buffer_bytes_q < LEN_W'(MIN_RING_BYTES)) begin
			size_w = LEN_W'(MIN_RING_BYTES);
		end else if (32'(buffer_bytes_q) > 32'(SIZE_MAX)) begin
			size_w = LEN_W'(SIZE_MAX);
		end else begin
			size_w = buffer_bytes_q;
		end
	end

	assign ft_w   = (fill_q < size_w) ? size_w - fill_q : '0;
	assign fc_raw = (LEN_W'(wr_pos_q) < size_w) ? size_w - LEN_W'(wr_pos_q) : '0;
	assign fc_w   = (fc_raw > ft_w) ? ft_w : fc_raw;

	assign acc_w        = (req_data.feed_length > ft_w) ? ft_w : req_data.feed_length;
	assign fill_feed_w  = fill_q + acc_w;
	assign fill_drain_w = fill_q - chunk_q;
	assign underrun_w   = (nch_q == '0) || (fill_q < chunk_q);

	assign slot_free = !res_valid_q || res_ready;
	assign ch_hit    = mask_q[idx_q];

	assign wrap_dvd = (state_q == ST_IDLE) ?
		SUM_W'(wr_pos_q) + SUM_W'(acc_w) : SUM_W'(rd_pos_q) + SUM_W'(chunk_q);

	crsb_wrap u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (wrap_start),
		.dividend  (wrap_dvd),
		.divisor   (size_w),
		.done      (wrap_done),
		.remainder (wrap_rem)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (req_data.action == ACT_CHUNK) ? ST_COUNT : ST_FEED_WRAP;
				end
			end
			ST_FEED_WRAP: begin
				if (wrap_done) state_d = ST_FEED_OUT;
			end
			ST_FEED_OUT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_COUNT: begin
				if (idx_q == CH_W'(MASK_W - 1)) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = underrun_w ? ST_UNDER : ST_DRAIN_WRAP;
			end
			ST_UNDER: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_DRAIN_WRAP: begin
				if (wrap_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (ch_hit && slot_free && nch_q == NCH_W'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		wrap_start = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				wrap_start = req_valid && (req_data.action == ACT_FEED);
			end
			ST_CHECK:    wrap_start = !underrun_w;
			ST_FEED_OUT: load_out   = slot_free;
			ST_UNDER:    load_out   = slot_free;
			ST_EMIT:     load_out   = slot_free && ch_hit;
			default: ;
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wr_pos_q      <= '0;
			rd_pos_q      <= '0;
			fill_q        <= '0;
			half_q        <= 1'b0;
			refill_sent_q <= 1'b0;
			idx_q         <= '0;
			nch_q         <= '0;
			req_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					nch_q <= '0;
					if (accept && req_data.action == ACT_FEED) begin
						fill_q <= fill_feed_w;
						if (fill_feed_w > refill_level_q) refill_sent_q <= 1'b0;
					end
				end
				ST_FEED_WRAP: begin
					if (wrap_done) wr_pos_q <= POS_W'(wrap_rem);
				end
				ST_COUNT: begin
					nch_q <= nch_q + NCH_W'(ch_hit);
					idx_q <= idx_q + CH_W'(1);
				end
				ST_CHECK: begin
					if (!underrun_w) begin
						half_q <= ~half_q;
						fill_q <= fill_drain_w;
						if (fill_drain_w <= refill_level_q && !refill_sent_q) begin
							req_q         <= 1'b1;
							refill_sent_q <= 1'b1;
						end else begin
							req_q <= 1'b0;
						end
					end
				end
				ST_DRAIN_WRAP: begin
					idx_q <= '0;
					if (wrap_done) rd_pos_q <= POS_W'(wrap_rem);
				end
				ST_EMIT: begin
					if (!ch_hit) begin
						idx_q <= idx_q + CH_W'(1);
					end else if (slot_free) begin
						idx_q <= idx_q + CH_W'(1);
						nch_q <= nch_q - NCH_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// word payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q  <= acc_w;
			mask_q <= channel_enable_q & VOICE_MASK;
		end
		if (state_q == ST_MUL) begin
			chunk_q <= LEN_W'(LEN_W'(interleave_q) * LEN_W'(nch_q));
		end
		if (state_q == ST_CHECK) begin
			start_q  <= rd_pos_q;
			offset_q <= '0;
			// half toggles at this edge, so the new half picks the area
			addr_q   <= target_base_q + (half_q ? '0 : ADDR_W'(chunk_q));
		end
		if (state_q == ST_EMIT && ch_hit && slot_free) begin
			offset_q <= offset_q + ADDR_W'(interleave_q);
		end
	end

	// ---------------- result word ----------------
	always_comb begin
		out_w                 = '0;
		out_w.kind            = KIND_FEED;
		out_w.read_offset     = OFS_W'(rd_pos_q);
		out_w.write_offset    = OFS_W'(wr_pos_q);
		out_w.free_contiguous = fc_w;
		out_w.free_total      = ft_w;
		out_w.fill_bytes      = fill_q;
		out_w.last            = 1'b1;
		case (state_q)
			ST_FEED_OUT: out_w.accepted_length = acc_q;
			ST_UNDER:    out_w.kind = KIND_UNDERRUN;
			ST_EMIT: begin
				out_w.kind           = KIND_LOOP;
				out_w.channel        = idx_q;
				out_w.loop_address   = addr_q + offset_q;
				out_w.upload_address = addr_q;
				out_w.read_offset    = OFS_W'(start_q);
				out_w.refill_request = req_q;
				out_w.last           = (nch_q == NCH_W'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) res_data_q <= out_w;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

// ----- design/crsb_checker.sv -----
// ----------------------------------------------------------------------------
// crsb_checker: port-level checks of the chunked ring stream buffer
// Watches the word channels and the result payload over time.
// ----------------------------------------------------------------------------
module crsb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 res_valid,
	input logic                 res_ready,
	input crsb_pkg::out_word_t  res_data
);
	import crsb_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result word changed while stalled");

	// one word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready right after an accepted word");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind != KIND_LOOP |-> res_data.last)
		else $error("feed report or underrun not marked last");

	a_no_addr_off_loop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind != KIND_LOOP |->
			res_data.channel == '0 && res_data.loop_address == '0 &&
			res_data.upload_address == '0)
		else $error("address fields set outside a loop entry");

	a_free_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.free_contiguous <= res_data.free_total)
		else $error("contiguous free space exceeds total free space");

endmodule

bind chunked_ring_stream_buffer crsb_checker u_crsb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the chunked ring stream buffer
// A directed table, then random phases under changing ring settings. Every
// result word is compared field by field against an in-bench ring predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import crsb_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_CYCLES     = 400;
	localparam int PRINT_LIMIT     = 30;
	localparam int RANDOM_PHASES   = 6;
	localparam int WORDS_PER_PHASE = 69;
	localparam int MAX_RING_BYTES  = 1048576;
	localparam int NUM_VOICES      = 24;
	localparam int MAX_FEED        = 1048576;
	localparam int N_DIRECTED      = 32;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [REG_IDX_W-1:0] reg_idx;
		logic                 action;
		logic [31:0]          value;
		bit                   typed;
		out_word_t            want;
	} plan_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [PDATA_W-1:0]  pwdata    = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                req_valid = 1'b0;
	logic                req_ready;
	in_word_t            req_data  = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	out_word_t           res_data;

	// in-bench ring predictor: settings and state
	int unsigned cfg_ring_bytes, cfg_interleave, cfg_chan_mask, cfg_refill, cfg_target;
	int unsigned m_write, m_read, m_fill;
	bit          m_half, m_refill_sent;

	out_word_t reports_due[$];

	int send_idle_pct, recv_idle_pct;
	logic hold_go = 1'b0;
	int hold_count = 0;
	int cycle_count = 0;
	int fault_count = 0;
	int results_seen = 0, feeds_sent = 0, chunks_sent = 0;
	int underruns_seen = 0, loops_seen = 0, refills_seen = 0;

	plan_row_t directed_plan [N_DIRECTED] = '{
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b1,
			'{kind: KIND_UNDERRUN, free_contiguous: 21'd65536, free_total: 21'd65536,
			last: 1'b1, default: '0}},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_FEED, 32'd0, 1'b1,
			'{kind: KIND_FEED, free_contiguous: 21'd65536, free_total: 21'd65536,
			last: 1'b1, default: '0}},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_FEED, 32'd1048576, 1'b1,
			'{kind: KIND_FEED, accepted_length: 21'd65536, fill_bytes: 21'd65536,
			last: 1'b1, default: '0}},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_FEED, 32'd1, 1'b1,
			'{kind: KIND_FEED, fill_bytes: 21'd65536, last: 1'b1, default: '0}},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_REG, REG_INTERLEAVE_BYTES, ACT_FEED, 32'd16384, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_REG, REG_CHANNEL_ENABLE, ACT_FEED, 32'hFFFFFF, 1'b0, '0},
		'{ROW_REG, REG_INTERLEAVE_BYTES, ACT_FEED, 32'd16, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_REG, REG_REFILL_LEVEL, ACT_FEED, 32'h1FFFFF, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_REG, REG_REFILL_LEVEL, ACT_FEED, 32'd0, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_FEED, 32'd4096, 1'b0, '0},
		'{ROW_REG, REG_CHANNEL_ENABLE, ACT_FEED, 32'd0, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_REG, REG_CHANNEL_ENABLE, ACT_FEED, 32'd1, 1'b0, '0},
		'{ROW_REG, REG_BUFFER_BYTES, ACT_FEED, 32'd0, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_FEED, 32'd7, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_REG, REG_BUFFER_BYTES, ACT_FEED, 32'h1FFFFF, 1'b0, '0},
		'{ROW_REG, REG_TARGET_BASE, ACT_FEED, 32'h7FFFF, 1'b0, '0},
		'{ROW_REG, REG_INTERLEAVE_BYTES, ACT_FEED, 32'hFFFF, 1'b0, '0},
		'{ROW_REG, REG_CHANNEL_ENABLE, ACT_FEED, 32'h800001, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_FEED, 32'd1048576, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'd0, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_FEED, 32'h0AAAAA, 1'b0, '0},
		'{ROW_REG, REG_INTERLEAVE_BYTES, ACT_FEED, 32'd0, 1'b0, '0},
		'{ROW_WORD, REG_BUFFER_BYTES, ACT_CHUNK, 32'h1FFFFF, 1'b0, '0}
	};

	chunked_ring_stream_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned ring_limit();
		if (cfg_ring_bytes < MIN_RING_BYTES) return MIN_RING_BYTES;
		if (cfg_ring_bytes > MAX_RING_BYTES) return MAX_RING_BYTES;
		return cfg_ring_bytes;
	endfunction

	// one conditional subtraction, then a modulo for offsets left stale by a resize
	function automatic int unsigned ring_advance(int unsigned pos, int unsigned len,
			int unsigned size);
		int unsigned sum;
		sum = pos + len;
		if (sum >= size) sum -= size;
		if (sum >= size) sum = sum % size;
		return sum;
	endfunction

	function automatic out_word_t status_report(logic [KIND_W-1:0] kind, int unsigned chan,
			int unsigned loop_a, int unsigned up_a, int unsigned rd, int unsigned acc,
			logic req, logic fin);
		int unsigned size, free_all, free_run;
		out_word_t r;
		size = ring_limit();
		free_all = (m_fill < size) ? size - m_fill : 0;
		free_run = (m_write < size) ? size - m_write : 0;
		if (free_run > free_all) free_run = free_all;
		r.kind            = kind;
		r.channel         = chan[CH_W-1:0];
		r.loop_address    = loop_a[ADDR_W-1:0];
		r.upload_address  = up_a[ADDR_W-1:0];
		r.read_offset     = rd[OFS_W-1:0];
		r.write_offset    = m_write[OFS_W-1:0];
		r.accepted_length = acc[LEN_W-1:0];
		r.free_contiguous = free_run[LEN_W-1:0];
		r.free_total      = free_all[LEN_W-1:0];
		r.fill_bytes      = m_fill[LEN_W-1:0];
		r.refill_request  = req;
		r.last            = fin;
		return r;
	endfunction

	function automatic void predict_reports(in_word_t w);
		int unsigned size, acc, mask, nch, chunk, start, base, offset, left;
		logic req;
		size = ring_limit();
		if (w.action == ACT_FEED) begin
			acc = w.feed_length;
			if (acc > ((m_fill < size) ? size - m_fill : 0))
				acc = (m_fill < size) ? size - m_fill : 0;
			m_fill = (m_fill + acc) & 32'h1FFFFF;
			m_write = ring_advance(m_write, acc, size);
			if (m_fill > cfg_refill) m_refill_sent = 1'b0;
			reports_due.push_back(status_report(KIND_FEED, 0, 0, 0, m_read, acc, 1'b0, 1'b1));
			return;
		end
		mask = cfg_chan_mask & ((32'd1 << NUM_VOICES) - 1);
		nch = $countones(mask);
		chunk = cfg_interleave * nch;
		if (nch == 0 || m_fill < chunk) begin
			reports_due.push_back(status_report(KIND_UNDERRUN, 0, 0, 0, m_read, 0, 1'b0, 1'b1));
			return;
		end
		m_half = !m_half;
		start = m_read;
		m_read = ring_advance(m_read, chunk, size);
		m_fill -= chunk;
		req = 1'b0;
		if (m_fill <= cfg_refill && !m_refill_sent) begin
			req = 1'b1;
			m_refill_sent = 1'b1;
		end
		base = (cfg_target + (m_half ? chunk : 0)) & 32'h7FFFF;
		offset = 0;
		left = nch;
		for (int ch = 0; ch < MASK_W; ch++) begin
			if (mask[ch]) begin
				left--;
				reports_due.push_back(status_report(KIND_LOOP, ch, (base + offset) & 32'h7FFFF,
					base, start, 0, req, left == 0));
				offset = (offset + cfg_interleave) & 32'h7FFFF;
			end
		end
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			if (fault_count <= PRINT_LIMIT)
				$display("%0t  %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// result side: check each accepted word against the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (res_data.kind == KIND_UNDERRUN) underruns_seen++;
			if (res_data.kind == KIND_LOOP) loops_seen++;
			if (res_data.refill_request && res_data.last) refills_seen++;
			if (reports_due.size() == 0) begin
				fault_count++;
				if (fault_count <= PRINT_LIMIT)
					$display("%0t  unexpected word: expected none, actual %p", $time, res_data);
			end else begin
				want = reports_due.pop_front();
				compare_field("kind", 32'(want.kind), 32'(res_data.kind));
				compare_field("channel", 32'(want.channel), 32'(res_data.channel));
				compare_field("loop_address", 32'(want.loop_address),
					32'(res_data.loop_address));
				compare_field("upload_address", 32'(want.upload_address),
					32'(res_data.upload_address));
				compare_field("read_offset", 32'(want.read_offset),
					32'(res_data.read_offset));
				compare_field("write_offset", 32'(want.write_offset),
					32'(res_data.write_offset));
				compare_field("accepted_length", 32'(want.accepted_length),
					32'(res_data.accepted_length));
				compare_field("free_contiguous", 32'(want.free_contiguous),
					32'(res_data.free_contiguous));
				compare_field("free_total", 32'(want.free_total), 32'(res_data.free_total));
				compare_field("fill_bytes", 32'(want.fill_bytes), 32'(res_data.fill_bytes));
				compare_field("refill_request", 32'(want.refill_request),
					32'(res_data.refill_request));
				compare_field("last", 32'(want.last), 32'(res_data.last));
			end
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_go && hold_count < HOLD_CYCLES) begin
			res_ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout at cycle %0d with %0d words outstanding",
				cycle_count, reports_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(logic action, logic [LEN_W-1:0] len, bit typed, out_word_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= '{action: action, feed_length: len};
		do @(posedge clk); while (!req_ready);
		predict_reports('{action: action, feed_length: len});
		if (typed) reports_due[reports_due.size() - 1] = want;
		if (action == ACT_FEED) feeds_sent++;
		else chunks_sent++;
	endtask

	// stop sending and wait until every predicted word has come back
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BUFFER_BYTES:     cfg_ring_bytes = value[LEN_W-1:0];
			REG_INTERLEAVE_BYTES: cfg_interleave = value[IL_W-1:0];
			REG_CHANNEL_ENABLE:   cfg_chan_mask  = value[MASK_W-1:0];
			REG_REFILL_LEVEL:     cfg_refill     = value[LEN_W-1:0];
			REG_TARGET_BASE:      cfg_target     = value[ADDR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// new ring settings for a random phase; sizes include clamped values
	task automatic choose_settings();
		int unsigned ring, eff, mask, nch, il_hi, il;
		case ($urandom_range(5))
			0: ring = $urandom_range(15);
			1: ring = $urandom_range(255, 16);
			2: ring = $urandom_range(8192, 256);
			3: ring = 65536;
			4: ring = $urandom_range(1048576, 8192);
			default: ring = $urandom_range(2097151, 1048577);
		endcase
		eff = (ring < MIN_RING_BYTES) ? MIN_RING_BYTES :
			(ring > MAX_RING_BYTES) ? MAX_RING_BYTES : ring;
		case ($urandom_range(3))
			0: mask = 32'd1 << $urandom_range(23);
			1: mask = $urandom & 32'hFFFFFF;
			2: mask = $urandom_range(15, 1);
			default: mask = 32'hFFFFFF;
		endcase
		if (mask == 0) mask = 1;
		nch = $countones(mask);
		il_hi = eff / (2 * nch);
		if (il_hi > 65535) il_hi = 65535;
		if (il_hi < 16) il_hi = 16;
		il = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(il_hi, 16);
		settle();
		write_register(REG_BUFFER_BYTES, ring);
		write_register(REG_INTERLEAVE_BYTES, il);
		write_register(REG_CHANNEL_ENABLE, mask);
		write_register(REG_REFILL_LEVEL, $urandom_range(eff));
		write_register(REG_TARGET_BASE, $urandom & 32'h7FFFF);
	endtask

	task automatic send_random_word();
		int unsigned eff, chunk, len;
		logic action;
		eff = ring_limit();
		chunk = cfg_interleave * $countones(cfg_chan_mask);
		action = ($urandom_range(99) < 45) ? ACT_CHUNK : ACT_FEED;
		case ($urandom_range(9))
			0: len = $urandom_range(MAX_FEED);
			1, 2: len = $urandom_range(eff);
			default: len = $urandom_range(chunk * 2 + 16);
		endcase
		if (len > MAX_FEED) len = MAX_FEED;
		send_word(action, len[LEN_W-1:0], 1'b0, '0);
	endtask

	initial begin
		cfg_ring_bytes = RST_BUFFER_BYTES;
		cfg_interleave = RST_INTERLEAVE_BYTES;
		cfg_chan_mask  = RST_CHANNEL_ENABLE;
		cfg_refill     = RST_REFILL_LEVEL;
		cfg_target     = RST_TARGET_BASE;
		m_write = 0;
		m_read = 0;
		m_fill = 0;
		m_half = 1'b0;
		m_refill_sent = 1'b0;
		send_idle_pct = 9;
		recv_idle_pct = 46;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_REG) begin
				settle();
				write_register(directed_plan[i].reg_idx, directed_plan[i].value);
			end else begin
				send_word(directed_plan[i].action, directed_plan[i].value[LEN_W-1:0],
					directed_plan[i].typed, directed_plan[i].want);
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 46;
				recv_idle_pct = 9;
			end
			if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			choose_settings();
			// long receiver stall while words keep coming
			if (phase == 1) hold_go <= 1'b1;
			repeat (WORDS_PER_PHASE) send_random_word();
		end

		settle();
		repeat (100) @(posedge clk);
		$display("Sent %0d feeds and %0d chunk requests over %0d ring settings",
			feeds_sent, chunks_sent, RANDOM_PHASES + 1);
		$display("Checked %0d result words: %0d loop entries, %0d underruns, %0d refills",
			results_seen, loops_seen, underruns_seen, refills_seen);
		if (fault_count == 0 && reports_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", fault_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
